// ===== sv/vsd_pkg.sv =====
// ----------------------------------------------------------------------------
// vsd_pkg: shared types and constants for the varint stream decoder
// Holds the lead byte boundaries, the value offsets and the token that the
// front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package vsd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned ValueW = 32;
    localparam int unsigned LeftW  = 3;

    // Lead byte boundaries.
    localparam logic [ByteW-1:0] LeadDirectMax = 8'd244;
    localparam logic [ByteW-1:0] LeadTwoMin    = 8'd245;
    localparam logic [ByteW-1:0] LeadTwoMax    = 8'd252;
    localparam logic [ByteW-1:0] LeadBe16      = 8'd253;
    localparam logic [ByteW-1:0] LeadLe24      = 8'd254;
    localparam logic [ByteW-1:0] LeadLe32      = 8'd255;

    // Offsets added to the payload of the short forms.
    localparam logic [ValueW-1:0] BaseTwo  = 32'd244;
    localparam logic [ValueW-1:0] BaseBe16 = 32'd2292;

    // Payload byte counts for each long form.
    localparam logic [LeftW-1:0] LenTwo  = 3'd1;
    localparam logic [LeftW-1:0] LenBe16 = 3'd2;
    localparam logic [LeftW-1:0] LenLe24 = 3'd3;
    localparam logic [LeftW-1:0] LenLe32 = 3'd4;

    // Status codes of a result.
    localparam logic StatusDone  = 1'b0;
    localparam logic StatusTrunc = 1'b1;

    typedef enum logic [1:0] {
        K_DIRECT = 2'd0,   // lead byte that is the whole value
        K_START  = 2'd1,   // lead byte of a multi-byte varint
        K_DATA   = 2'd2    // payload byte
    } t_kind;

    typedef struct packed {
        logic [ByteW-1:0] data;
        t_kind            kind;
        logic             done;    // payload byte that completes the varint
        logic             trunc;   // buffer ended before the varint completed
    } t_token;

endpackage

// ===== sv/varint_stream_decoder_32.sv =====
// ----------------------------------------------------------------------------
// varint_stream_decoder_32: streaming decoder for 32-bit varints
// Decodes lead-byte-selected variable-length unsigned integers from a byte
// stream and emits one result per completed or truncated varint.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one raw byte per transaction; tlast marks the
//   last byte of a buffer. The output stream carries one result per varint:
//   the decoded value in tdata and a status bit in tuser (0 complete,
//   1 buffer ended inside a varint, with a zero value).
//   Bytes that do not finish a varint produce no output transaction.
//   Throughput is one byte per cycle while s_axis_tready is high, set by
//   the accumulate and value update in the back end. A completing byte is
//   registered in the queue, then its result in the output register.
//   A queue of FIFO_DEPTH tokens sits between the classifier and the decoder,
//   so the input keeps flowing while a result waits; once the output stalls
//   long enough to fill it, s_axis_tready drops until results are taken.
//   Reset empties the queue, clears the output valid flag and returns the
//   decoder to its idle state between varints.
// ----------------------------------------------------------------------------
module varint_stream_decoder_32 #(
    parameter int unsigned FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic        s_axis_tlast,    // buffer_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [31:0] decoded_value
    output logic [0:0]  m_axis_tuser     // [0] status
);

    logic            in_accept;
    logic            fifo_full;
    logic            fifo_valid;
    logic            fifo_pop;
    vsd_pkg::t_token front_token;
    vsd_pkg::t_token fifo_token;
    logic            back_status;

    assign s_axis_tready = !fifo_full;
    assign in_accept     = s_axis_tvalid && !fifo_full;
    assign m_axis_tuser  = back_status;

    vsd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_token  (front_token)
    );

    vsd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_token (front_token),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_valid (fifo_valid),
        .o_token (fifo_token)
    );

    vsd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (fifo_valid),
        .i_token  (fifo_token),
        .o_pop    (fifo_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_value  (m_axis_tdata),
        .o_status (back_status)
    );

endmodule

// ===== sv/vsd_front.sv =====
// ----------------------------------------------------------------------------
// vsd_front: byte classifier
// Tracks how many payload bytes the current varint still needs and tags each
// accepted byte as a direct value, a lead byte or a payload byte.
// ----------------------------------------------------------------------------
module vsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output vsd_pkg::t_token o_token
);

    logic [vsd_pkg::LeftW-1:0] r_left;
    logic [vsd_pkg::LeftW-1:0] n_left;
    logic [vsd_pkg::LeftW-1:0] lead_len;

    always_comb begin
        if (i_byte <= vsd_pkg::LeadTwoMax) begin
            lead_len = vsd_pkg::LenTwo;
        end else if (i_byte == vsd_pkg::LeadBe16) begin
            lead_len = vsd_pkg::LenBe16;
        end else if (i_byte == vsd_pkg::LeadLe24) begin
            lead_len = vsd_pkg::LenLe24;
        end else begin
            lead_len = vsd_pkg::LenLe32;
        end
    end

    always_comb begin
        o_token.data  = i_byte;
        o_token.kind  = vsd_pkg::K_DATA;
        o_token.done  = 1'b0;
        o_token.trunc = 1'b0;
        n_left        = r_left;
        if (r_left == '0) begin
            if (i_byte <= vsd_pkg::LeadDirectMax) begin
                o_token.kind = vsd_pkg::K_DIRECT;
            end else begin
                o_token.kind  = vsd_pkg::K_START;
                o_token.trunc = i_last;
                n_left        = i_last ? '0 : lead_len;
            end
        end else begin
            o_token.done  = (r_left == vsd_pkg::LeftW'(1));
            o_token.trunc = (r_left != vsd_pkg::LeftW'(1)) && i_last;
            n_left        = i_last ? '0 : r_left - vsd_pkg::LeftW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (i_accept) begin
            r_left <= n_left;
        end
    end

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= vsd_pkg::LenLe32)
        else $error("front: payload count out of range");

    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (o_token.done || o_token.trunc) |=> r_left == '0)
        else $error("front: count not cleared at end of varint");

endmodule

// ===== sv/vsd_fifo.sv =====
// ----------------------------------------------------------------------------
// vsd_fifo: token queue
// Short register queue between the classifier and the decoder; a push and a
// pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module vsd_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vsd_pkg::t_token i_token,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output vsd_pkg::t_token o_token
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);

    vsd_pkg::t_token r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
        ptr_next = (ptr == PtrW'(DEPTH - 1)) ? '0 : ptr + PtrW'(1);
    endfunction

    assign o_full  = (r_count == CntW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("fifo: occupancy above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + CntW'(1))
        else $error("fifo: occupancy did not grow on push");

endmodule

// ===== sv/vsd_back.sv =====
// ----------------------------------------------------------------------------
// vsd_back: payload accumulator and result register
// Gathers payload bytes, forms the decoded value when a varint completes and
// holds each result until the output side takes it.
// ----------------------------------------------------------------------------
module vsd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  vsd_pkg::t_token i_token,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_value,
    output logic            o_status
);

    logic [7:0]  r_lead;
    logic [31:0] r_accum;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic        r_out_status;

    logic [31:0] n_accum;
    logic [7:0]  lead_off;
    logic [31:0] value;
    logic        emit;
    logic [31:0] emit_value;
    logic        emit_status;

    assign o_pop    = i_valid && (!r_out_valid || i_ready);
    assign o_valid  = r_out_valid;
    assign o_value  = r_out_value;
    assign o_status = r_out_status;
    assign lead_off = r_lead - vsd_pkg::LeadTwoMin;

    always_comb begin
        // Big-endian and one-byte forms shift in from the bottom and keep
        // 16 bits; the little-endian forms place each byte at its own lane.
        if (r_lead <= vsd_pkg::LeadBe16) begin
            n_accum = {16'b0, r_accum[7:0], i_token.data};
        end else begin
            n_accum = r_accum | ({24'b0, i_token.data} << {r_idx, 3'b000});
        end
    end

    always_comb begin
        if (r_lead <= vsd_pkg::LeadTwoMax) begin
            value = vsd_pkg::BaseTwo + {21'b0, lead_off[2:0], i_token.data};
        end else if (r_lead == vsd_pkg::LeadBe16) begin
            value = vsd_pkg::BaseBe16 + {16'b0, n_accum[15:0]};
        end else if (r_lead == vsd_pkg::LeadLe24) begin
            value = {8'b0, n_accum[23:0]};
        end else begin
            value = n_accum;
        end
    end

    always_comb begin
        emit        = 1'b0;
        emit_value  = '0;
        emit_status = vsd_pkg::StatusDone;
        unique case (i_token.kind)
            vsd_pkg::K_DIRECT: begin
                emit       = 1'b1;
                emit_value = {24'b0, i_token.data};
            end
            vsd_pkg::K_START: begin
                emit        = i_token.trunc;
                emit_status = vsd_pkg::StatusTrunc;
            end
            vsd_pkg::K_DATA: begin
                if (i_token.done) begin
                    emit       = 1'b1;
                    emit_value = value;
                end else if (i_token.trunc) begin
                    emit        = 1'b1;
                    emit_status = vsd_pkg::StatusTrunc;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead  <= '0;
            r_accum <= '0;
            r_idx   <= '0;
        end else if (o_pop) begin
            if (i_token.kind == vsd_pkg::K_START) begin
                r_lead  <= i_token.data;
                r_accum <= '0;
                r_idx   <= '0;
            end else if (i_token.kind == vsd_pkg::K_DATA) begin
                r_accum <= n_accum;
                r_idx   <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_value  <= emit_value;
            r_out_status <= emit_status;
        end
    end

    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == vsd_pkg::StatusTrunc |-> r_out_value == '0)
        else $error("back: truncation result carries a nonzero value");

    a_no_pop_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_ready |-> !o_pop)
        else $error("back: token taken while result is stalled");

endmodule
